FILE: rtl/core/rmj_pkg.sv
// Shared types and constants of the radar measurement Jacobian block.
`default_nettype none
package rmj_pkg;

  localparam int CFG_W  = 17;
  localparam int ADDR_W = 3;

  localparam logic [CFG_W-1:0] MIN_CUBE_RESET = 17'd7;

  // Register index, taken from the upper address bits.
  localparam logic [ADDR_W-3:0] REG_MIN_CUBE_RADIUS = 1'b0;

  typedef struct packed {
    logic adv;
    logic vld;
  } pipe_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/rmj_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a passed-along sideband.
`default_nettype none
module rmj_isqrt #(
  parameter int RW  = 32,
  parameter int SBW = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rmj_pkg::pipe_ctl_t ctl_i,
  input  wire logic [2*RW-1:0]    rad_i,
  input  wire logic [SBW-1:0]     sb_i,
  output logic                    vld_o,
  output logic [RW-1:0]           root_o,
  output logic [SBW-1:0]          sb_o
);
  import rmj_pkg::*;

  localparam int IW = 2 * RW + 1;

  logic [RW:0]        vld_q;
  logic [2*RW-1:0]    rem_q  [RW+1];
  logic [RW-1:0]      root_q [RW+1];
  logic [SBW-1:0]     sb_q   [RW+1];

  always_comb begin
    vld_q[0]  = ctl_i.vld;
    rem_q[0]  = rad_i;
    root_q[0] = '0;
    sb_q[0]   = sb_i;
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [IW-1:0] inc;
    logic          hit;

    always_comb begin
      inc = (IW'(root_q[k]) << (B + 1)) + (IW'(1) << (2 * B));
      hit = ({1'b0, rem_q[k]} >= inc);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rem_q[k+1]  <= hit ? (rem_q[k] - inc[2*RW-1:0]) : rem_q[k];
        root_q[k+1] <= root_q[k] | (RW'(hit) << B);
        sb_q[k+1]   <= sb_q[k];
      end
    end
  end

  assign vld_o  = vld_q[RW];
  assign root_o = root_q[RW];
  assign sb_o   = sb_q[RW];

endmodule
`default_nettype wire

FILE: rtl/core/rmj_div.sv
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
`default_nettype none
module rmj_div #(
  parameter int NW  = 48,
  parameter int DW  = 32,
  parameter int QW  = 32,
  parameter int SBW = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rmj_pkg::pipe_ctl_t ctl_i,
  input  wire logic [NW-1:0]      num_i,
  input  wire logic [DW-1:0]      den_i,
  input  wire logic               neg_i,
  input  wire logic [SBW-1:0]     sb_i,
  output logic                    vld_o,
  output logic signed [QW-1:0]    res_o,
  output logic [SBW-1:0]          sb_o
);
  import rmj_pkg::*;

  localparam int XW = NW + DW + QW;
  localparam logic [QW-1:0] MAX_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] MAX_NEG = {1'b1, {(QW-1){1'b0}}};

  logic [QW:0]     vld_q;
  logic [NW-1:0]   rem_q [QW+1];
  logic [DW-1:0]   den_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic [QW:0]     ovf_q;
  logic [QW:0]     neg_q;
  logic [SBW-1:0]  sb_q  [QW+1];
  logic            ovf_d;
  logic [QW-1:0]   mag;

  assign ovf_d = (XW'(num_i) >= (XW'(den_i) << QW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q[0] <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= ovf_d;
      neg_q[0] <= neg_i;
      sb_q[0]  <= sb_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [XW-1:0] trial;
    logic          hit;

    always_comb begin
      trial = XW'(den_q[k]) << B;
      hit   = (XW'(rem_q[k]) >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rem_q[k+1] <= hit ? (rem_q[k] - trial[NW-1:0]) : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_q[k] | (QW'(hit) << B);
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  assign mag = quo_q[QW];

  always_comb begin
    if (neg_q[QW]) begin
      if (ovf_q[QW] || (mag[QW-1] && (|mag[QW-2:0]))) begin
        res_o = MAX_NEG;
      end else begin
        res_o = ~mag + 1'b1;
      end
    end else begin
      if (ovf_q[QW] || mag[QW-1]) begin
        res_o = MAX_POS;
      end else begin
        res_o = mag;
      end
    end
  end

  assign vld_o = vld_q[QW];
  assign sb_o  = sb_q[QW];

endmodule
`default_nettype wire

FILE: rtl/core/rmj_obuf.sv
// Two-entry output buffer that lets the pipeline run while a word waits downstream.
`default_nettype none
module rmj_obuf #(
  parameter int PW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [PW-1:0] data_i,
  output logic               full_o,
  output logic               valid_o,
  output logic [PW-1:0]      data_o,
  input  wire logic          stall_i
);
  import rmj_pkg::*;

  logic [1:0]    cnt_q, cnt_d;
  logic [PW-1:0] slot0_q, slot1_q;
  logic          pop;

  assign pop     = (cnt_q != 2'd0) && !stall_i;
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot0_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cnt_q)
      2'd0: begin
        if (push_i) begin
          slot0_q <= data_i;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          slot0_q <= data_i;
        end else if (push_i) begin
          slot1_q <= data_i;
        end
      end
      default: begin
        if (pop) begin
          slot0_q <= slot1_q;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/radar_measurement_jacobian.sv
// Top level of the radar measurement Jacobian pipeline with its register port.
//
//   channel | direction | handshake                  | payload
//   input   | in        | in_valid_i / in_stall_o    | pos_x_i pos_y_i vel_x_i vel_y_i
//   output  | out       | out_valid_o / out_stall_i  | six entries and near_origin_o
//   config  | in        | psel penable pwrite pready | paddr pwdata, prdata
//
// One word is accepted per cycle while in_stall_o is low. A word passes three
// front stages, one square-root stage per root bit, two product stages, one
// divider stage per quotient bit plus its range check, and the output buffer.
// Reset clears all valid bits and sets the threshold to its default. A stall
// freezes the whole pipeline only once the two-entry output buffer is full.
`default_nettype none
module radar_measurement_jacobian #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [WORD_BITS-1:0]   pos_x_i,
  input  wire logic signed [WORD_BITS-1:0]   pos_y_i,
  input  wire logic signed [WORD_BITS-1:0]   vel_x_i,
  input  wire logic signed [WORD_BITS-1:0]   vel_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [WORD_BITS-1:0]        range_by_px_o,
  output logic signed [WORD_BITS-1:0]        range_by_py_o,
  output logic signed [WORD_BITS-1:0]        bearing_by_px_o,
  output logic signed [WORD_BITS-1:0]        bearing_by_py_o,
  output logic signed [WORD_BITS-1:0]        rate_by_px_o,
  output logic signed [WORD_BITS-1:0]        rate_by_py_o,
  output logic                               near_origin_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rmj_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rmj_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int SRW  = 3 * W;
  localparam int SQSB = 6 * W + 3;
  localparam int PW   = 6 * W + 1;

  logic             en, full;
  logic [CFG_W-1:0] thr_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= MIN_CUBE_RESET;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_MIN_CUBE_RADIUS)) begin
      thr_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_MIN_CUBE_RADIUS) ? 32'(thr_q) : 32'd0;

  assign en         = !full;
  assign in_stall_o = full;

  // Stage 1: magnitudes and signs.
  logic         v1_q;
  logic [W-1:0] mp1_q, mq1_q, mu1_q, mv1_q;
  logic         np1_q, nq1_q, nu1_q, nv1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mp1_q <= pos_x_i[W-1] ? (~$unsigned(pos_x_i) + 1'b1) : $unsigned(pos_x_i);
      mq1_q <= pos_y_i[W-1] ? (~$unsigned(pos_y_i) + 1'b1) : $unsigned(pos_y_i);
      mu1_q <= vel_x_i[W-1] ? (~$unsigned(vel_x_i) + 1'b1) : $unsigned(vel_x_i);
      mv1_q <= vel_y_i[W-1] ? (~$unsigned(vel_y_i) + 1'b1) : $unsigned(vel_y_i);
      np1_q <= pos_x_i[W-1];
      nq1_q <= pos_y_i[W-1];
      nu1_q <= vel_x_i[W-1];
      nv1_q <= vel_y_i[W-1];
    end
  end

  // Stage 2: squares and cross products.
  logic           v2_q;
  logic [2*W-1:0] pp2_q, qq2_q, uq2_q, vp2_q;
  logic [W-1:0]   mp2_q, mq2_q;
  logic           np2_q, nq2_q, na2_q, nb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp2_q <= mp1_q * mp1_q;
      qq2_q <= mq1_q * mq1_q;
      uq2_q <= mu1_q * mq1_q;
      vp2_q <= mv1_q * mp1_q;
      mp2_q <= mp1_q;
      mq2_q <= mq1_q;
      np2_q <= np1_q;
      nq2_q <= nq1_q;
      na2_q <= nu1_q ^ nq1_q;
      nb2_q <= !(nv1_q ^ np1_q);
    end
  end

  // Stage 3: r squared and the signed cross term.
  logic           v3_q;
  logic [2*W-1:0] s3_q, c3_q;
  logic           nc3_q;
  logic [W-1:0]   mp3_q, mq3_q;
  logic           np3_q, nq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= pp2_q + qq2_q;
      if (na2_q == nb2_q) begin
        c3_q  <= uq2_q + vp2_q;
        nc3_q <= na2_q;
      end else if (uq2_q >= vp2_q) begin
        c3_q  <= uq2_q - vp2_q;
        nc3_q <= na2_q;
      end else begin
        c3_q  <= vp2_q - uq2_q;
        nc3_q <= nb2_q;
      end
      mp3_q <= mp2_q;
      mq3_q <= mq2_q;
      np3_q <= np2_q;
      nq3_q <= nq2_q;
    end
  end

  // Square root of r squared.
  pipe_ctl_t      sq_ctl;
  logic           vsq;
  logic [W-1:0]   r_sq;
  logic [SQSB-1:0] sb_sq;
  logic [2*W-1:0] s_sq, c_sq;
  logic           nc_sq, np_sq, nq_sq;
  logic [W-1:0]   mp_sq, mq_sq;

  assign sq_ctl = '{adv: en, vld: v3_q};

  rmj_isqrt #(
    .RW  (W),
    .SBW (SQSB)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .rad_i  (s3_q),
    .sb_i   ({s3_q, c3_q, nc3_q, mp3_q, mq3_q, np3_q, nq3_q}),
    .vld_o  (vsq),
    .root_o (r_sq),
    .sb_o   (sb_sq)
  );

  assign {s_sq, c_sq, nc_sq, mp_sq, mq_sq, np_sq, nq_sq} = sb_sq;

  // Stage 4: partial products of r cubed and of the rate numerators.
  logic           v4_q;
  logic [2*W-1:0] srl4_q, srh4_q, qcl4_q, qch4_q, pcl4_q, pch4_q;
  logic [W-1:0]   r4_q, mp4_q, mq4_q;
  logic [2*W-1:0] s4_q;
  logic           nc4_q, np4_q, nq4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vsq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srl4_q <= s_sq[W-1:0] * r_sq;
      srh4_q <= s_sq[2*W-1:W] * r_sq;
      qcl4_q <= c_sq[W-1:0] * mq_sq;
      qch4_q <= c_sq[2*W-1:W] * mq_sq;
      pcl4_q <= c_sq[W-1:0] * mp_sq;
      pch4_q <= c_sq[2*W-1:W] * mp_sq;
      r4_q   <= r_sq;
      s4_q   <= s_sq;
      mp4_q  <= mp_sq;
      mq4_q  <= mq_sq;
      nc4_q  <= nc_sq;
      np4_q  <= np_sq;
      nq4_q  <= nq_sq;
    end
  end

  // Stage 5: sums of partial products and the near-origin test.
  logic           v5_q;
  logic [SRW-1:0] sr_d, sr5_q, qc5_q, pc5_q;
  logic [W-1:0]   r5_q, mp5_q, mq5_q;
  logic [2*W-1:0] s5_q;
  logic [5:0]     neg5_q;
  logic           near_d, near5_q;

  assign sr_d   = SRW'(srl4_q) + (SRW'(srh4_q) << W);
  assign near_d = (s4_q == '0) || (sr_d < (SRW'(thr_q) << (2 * F)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr5_q   <= sr_d;
      qc5_q   <= SRW'(qcl4_q) + (SRW'(qch4_q) << W);
      pc5_q   <= SRW'(pcl4_q) + (SRW'(pch4_q) << W);
      near5_q <= near_d;
      r5_q    <= r4_q;
      s5_q    <= s4_q;
      mp5_q   <= mp4_q;
      mq5_q   <= mq4_q;
      neg5_q  <= {!(np4_q ^ nc4_q), nq4_q ^ nc4_q, np4_q, !nq4_q, nq4_q, np4_q};
    end
  end

  // Six dividers in lockstep.
  pipe_ctl_t             dv_ctl;
  logic                  vdv, near_dv;
  logic signed [W-1:0]   q0, q1, q2, q3, q4, q5;
  logic [PW-1:0]         ob_in, ob_out;

  assign dv_ctl = '{adv: en, vld: v5_q};

  rmj_div #(.NW(W + F), .DW(W), .QW(W), .SBW(1)) u_div_rpx (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dv_ctl),
    .num_i ({mp5_q, {F{1'b0}}}), .den_i (r5_q), .neg_i (neg5_q[0]), .sb_i (near5_q),
    .vld_o (vdv), .res_o (q0), .sb_o (near_dv)
  );

  rmj_div #(.NW(W + F), .DW(W), .QW(W), .SBW(1)) u_div_rpy (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dv_ctl),
    .num_i ({mq5_q, {F{1'b0}}}), .den_i (r5_q), .neg_i (neg5_q[1]), .sb_i (1'b0),
    .vld_o (), .res_o (q1), .sb_o ()
  );

  rmj_div #(.NW(W + 2 * F), .DW(2 * W), .QW(W), .SBW(1)) u_div_bpx (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dv_ctl),
    .num_i ({mq5_q, {(2 * F){1'b0}}}), .den_i (s5_q), .neg_i (neg5_q[2]), .sb_i (1'b0),
    .vld_o (), .res_o (q2), .sb_o ()
  );

  rmj_div #(.NW(W + 2 * F), .DW(2 * W), .QW(W), .SBW(1)) u_div_bpy (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dv_ctl),
    .num_i ({mp5_q, {(2 * F){1'b0}}}), .den_i (s5_q), .neg_i (neg5_q[3]), .sb_i (1'b0),
    .vld_o (), .res_o (q3), .sb_o ()
  );

  rmj_div #(.NW(SRW + F), .DW(SRW), .QW(W), .SBW(1)) u_div_tpx (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dv_ctl),
    .num_i ({qc5_q, {F{1'b0}}}), .den_i (sr5_q), .neg_i (neg5_q[4]), .sb_i (1'b0),
    .vld_o (), .res_o (q4), .sb_o ()
  );

  rmj_div #(.NW(SRW + F), .DW(SRW), .QW(W), .SBW(1)) u_div_tpy (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dv_ctl),
    .num_i ({pc5_q, {F{1'b0}}}), .den_i (sr5_q), .neg_i (neg5_q[5]), .sb_i (1'b0),
    .vld_o (), .res_o (q5), .sb_o ()
  );

  assign ob_in = near_dv ? {{(6 * W){1'b0}}, 1'b1}
                         : {q0, q1, q2, q3, q4, q5, 1'b0};

  rmj_obuf #(
    .PW (PW)
  ) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (vdv && en),
    .data_i  (ob_in),
    .full_o  (full),
    .valid_o (out_valid_o),
    .data_o  (ob_out),
    .stall_i (out_stall_i)
  );

  assign {range_by_px_o, range_by_py_o, bearing_by_px_o, bearing_by_py_o,
          rate_by_px_o, rate_by_py_o, near_origin_o} = ob_out;

endmodule
`default_nettype wire

FILE: rtl/core/rmj_checker.sv
// Port-level checks of the radar measurement Jacobian and their binding to the top level.
`default_nettype none
module rmj_checker #(
  parameter int WORD_BITS = 32
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic signed [WORD_BITS-1:0] range_by_px_o,
  input wire logic signed [WORD_BITS-1:0] range_by_py_o,
  input wire logic signed [WORD_BITS-1:0] bearing_by_px_o,
  input wire logic signed [WORD_BITS-1:0] bearing_by_py_o,
  input wire logic signed [WORD_BITS-1:0] rate_by_px_o,
  input wire logic signed [WORD_BITS-1:0] rate_by_py_o,
  input wire logic                        near_origin_o
);
  import rmj_pkg::*;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(range_by_px_o) && $stable(rate_by_py_o)
      && $stable(bearing_by_px_o) && $stable(near_origin_o))
    else $error("output word changed while stalled");

  a_near_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && near_origin_o |-> (range_by_px_o == '0) && (range_by_py_o == '0)
      && (bearing_by_px_o == '0) && (bearing_by_py_o == '0)
      && (rate_by_px_o == '0) && (rate_by_py_o == '0))
    else $error("entries not cleared near origin");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output word pending");

endmodule

bind radar_measurement_jacobian rmj_checker #(.WORD_BITS(WORD_BITS)) u_rmj_checker (.*);
`default_nettype wire

FILE: dv/tb_radar_measurement_jacobian.sv
// Self-checking testbench for the radar measurement Jacobian pipeline.
`default_nettype none
module tb_radar_measurement_jacobian;
  import rmj_pkg::*;

  typedef struct packed {
    logic [31:0] range_px;
    logic [31:0] range_py;
    logic [31:0] bearing_px;
    logic [31:0] bearing_py;
    logic [31:0] rate_px;
    logic [31:0] rate_py;
    logic        near;
  } jacobian_t;

  class jacobian_scoreboard;
    jacobian_t     expected_q[$];
    logic [16:0]   threshold = MIN_CUBE_RESET;
    int            errors = 0;

    function bit [191:0] magnitude(logic [31:0] x);
      return x[31] ? {160'd0, 32'(~x + 32'd1)} : {160'd0, x};
    endfunction

    function logic [31:0] saturated_quotient(bit [191:0] n, bit [191:0] d, bit neg);
      bit [191:0] q;
      if (n >= (d << 32)) q = 192'hFFFF_FFFF;
      else q = n / d;
      if (neg) begin
        if (q > 192'h8000_0000) q = 192'h8000_0000;
        return 32'(~q[31:0] + 32'd1);
      end
      if (q > 192'h7FFF_FFFF) q = 192'h7FFF_FFFF;
      return q[31:0];
    endfunction

    function void note_state(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                             logic [31:0] vy);
      bit [191:0] mp, mq, mu, mv, s, r, t, sr, a, b, c;
      bit np, nq, na, nb, nc;
      jacobian_t e;
      mp = magnitude(px); mq = magnitude(py);
      mu = magnitude(vx); mv = magnitude(vy);
      np = px[31]; nq = py[31];
      s = mp * mp + mq * mq;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (192'd1 << i);
        if (t * t <= s) r = t;
      end
      sr = s * r;
      e = '0;
      if (s == 0 || sr < ({175'd0, threshold} << 32)) begin
        e.near = 1'b1;
      end else begin
        a = mu * mq;
        na = vx[31] ^ nq;
        b = mv * mp;
        nb = !(vy[31] ^ np);
        if (na == nb) begin
          c = a + b; nc = na;
        end else if (a >= b) begin
          c = a - b; nc = na;
        end else begin
          c = b - a; nc = nb;
        end
        e.range_px   = saturated_quotient(mp << 16, r, np);
        e.range_py   = saturated_quotient(mq << 16, r, nq);
        e.bearing_px = saturated_quotient(mq << 32, s, !nq);
        e.bearing_py = saturated_quotient(mp << 32, s, np);
        e.rate_px    = saturated_quotient((mq * c) << 16, sr, nq ^ nc);
        e.rate_py    = saturated_quotient((mp * c) << 16, sr, !(np ^ nc));
      end
      expected_q.push_back(e);
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(jacobian_t act);
      jacobian_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("range_by_px", e.range_px, act.range_px);
      compare("range_by_py", e.range_py, act.range_py);
      compare("bearing_by_px", e.bearing_px, act.bearing_px);
      compare("bearing_by_py", e.bearing_py, act.bearing_py);
      compare("rate_by_px", e.rate_px, act.rate_px);
      compare("rate_by_py", e.rate_py, act.rate_py);
      compare("near_origin", {31'd0, e.near}, {31'd0, act.near});
    endfunction
  endclass

  localparam int LATENCY = 2 * 32 + 7;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_stall_o, out_valid_o, near_origin_o, pready;
  logic signed [31:0] range_by_px_o, range_by_py_o, bearing_by_px_o, bearing_by_py_o;
  logic signed [31:0] rate_by_px_o, rate_by_py_o;
  logic [31:0] prdata;

  jacobian_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  long_hold_req = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  radar_measurement_jacobian DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .pos_x_i, .pos_y_i, .vel_x_i, .vel_y_i,
    .out_valid_o, .out_stall_i, .range_by_px_o, .range_by_py_o, .bearing_by_px_o,
    .bearing_by_py_o, .rate_by_px_o, .rate_by_py_o, .near_origin_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_state(pos_x_i, pos_y_i, vel_x_i, vel_y_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({range_by_px_o, range_by_py_o, bearing_by_px_o, bearing_by_py_o,
                       rate_by_px_o, rate_by_py_o, near_origin_o});
    end
    if ((rst_ni && in_valid_i && !in_stall_o) || (rst_ni && out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_state(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                            logic [31:0] vy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px; pos_y_i <= py; vel_x_i <= vx; vel_y_i <= vy;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[ADDR_W-1:2] == REG_MIN_CUBE_RADIUS) sb.threshold = value[16:0];
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(0, 1 << 20);
      2: v = $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
    endcase
    if ($urandom_range(1)) v = ~v + 32'd1;
    return v;
  endfunction

  task automatic directed_states();
    send_state(0, 0, 0, 0);
    send_state(32'h0000_0001, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(0, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'h0000_0100, 32'h0000_0080, 32'h0001_0000, 32'hFFFF_0000);
    send_state(32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000);
    send_state(0, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
    send_state(32'h0003_0000, 32'h0004_0000, 32'hFFFF_8000, 32'h0000_8000);
    send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_state(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_state(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_state(32'h0000_0010, 32'hFFFF_FFF0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_state(32'h0000_4000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_states();
    drain();
    write_reg({REG_MIN_CUBE_RADIUS, 2'b00}, 32'd0);
    write_reg(3'd4, 32'h0001_FFFF);
    directed_states();
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: write_reg({REG_MIN_CUBE_RADIUS, 2'b00}, 32'd65536);
        1: write_reg({REG_MIN_CUBE_RADIUS, 2'b00}, 32'd7);
        default: write_reg({REG_MIN_CUBE_RADIUS, 2'b00}, $urandom_range(0, 65536));
      endcase
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 54 : 0;
      recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 16 : 0;
      for (int n = 0; n < 500; n++) begin
        if (phase == 0 && n == 100) long_hold_req = 1'b1;
        if (phase == 2 && n == 250) drain();
        send_state(random_word(), random_word(), random_word(), random_word());
      end
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
